@@ sv/matrix_vector_multiply_assert.svh @@
// assertion macros for the matrix vector multiply block
// clocked on clk_i, quiet while rst_ni is low
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS

`define MVM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define MVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define MVM_ASSERT_SAME(label, ante, cons)

`define MVM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/mvm_pkg.sv @@
package mvm_pkg;

  // configuration register indexes
  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_e;

  localparam int unsigned CountW    = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned RowIndexW = 4;
  localparam logic [CountW-1:0] CountReset = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic mat_wr;
    logic vec_wr;
    logic rd;
    logic acc_clr;
    logic out_load;
    logic out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } stat_t;

endpackage

@@ sv/mvm_ctrl.sv @@
module mvm_ctrl #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16,
  localparam int unsigned MaxProd = MAX_ROWS * MAX_COLS,
  localparam int unsigned AW  = (MaxProd > 1) ? $clog2(MaxProd) : 1,
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mvm_pkg::CountW-1:0]  row_count_i,
  input  logic [mvm_pkg::CountW-1:0]  column_count_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mvm_pkg::stat_t              stat_i,
  output mvm_pkg::cmd_t               cmd_o,
  output logic [AW-1:0]               mat_addr_o,
  output logic [CW-1:0]               vec_addr_o,
  output logic [mvm_pkg::RowIndexW-1:0] out_row_o
);
  import mvm_pkg::*;

  localparam int unsigned PW  = $clog2(MaxProd + 1);
  localparam int unsigned RLW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CLW = $clog2(MAX_COLS + 1);
  localparam int unsigned MW  = RLW + CLW;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [PW-1:0]    pos_q, pos_d, pos_inc;
  logic             vec_phase_q, vec_phase_d;
  logic [RLW-1:0]   rows_q, rows_d, row_q, row_d, rows_eff;
  logic [CLW-1:0]   cols_q, cols_d, col_q, col_d, cols_eff;
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic [MW-1:0]    rc_eff;

  // counts of zero act as one, counts above the maximum act as the maximum
  always_comb begin
    if (row_count_i == '0) begin
      rows_eff = RLW'(1);
    end else if (int'(row_count_i) > int'(MAX_ROWS)) begin
      rows_eff = RLW'(MAX_ROWS);
    end else begin
      rows_eff = RLW'(row_count_i);
    end
    if (column_count_i == '0) begin
      cols_eff = CLW'(1);
    end else if (int'(column_count_i) > int'(MAX_COLS)) begin
      cols_eff = CLW'(MAX_COLS);
    end else begin
      cols_eff = CLW'(column_count_i);
    end
  end

  assign rc_eff  = MW'(rows_eff) * MW'(cols_eff);
  assign pos_inc = PW'(pos_q + 1'b1);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    vec_phase_d = vec_phase_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    row_d       = row_q;
    col_d       = col_q;
    rd_addr_d   = rd_addr_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    mat_addr_o  = pos_q[AW-1:0];
    vec_addr_o  = pos_q[CW-1:0];
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!vec_phase_q) begin
            cmd_o.mat_wr = 1'b1;
            if (MW'(pos_inc) >= rc_eff) begin
              pos_d       = '0;
              vec_phase_d = 1'b1;
            end else begin
              pos_d = pos_inc;
            end
          end else begin
            cmd_o.vec_wr = 1'b1;
            if (CLW'(pos_inc) >= cols_eff) begin
              pos_d         = '0;
              vec_phase_d   = 1'b0;
              rows_d        = rows_eff;
              cols_d        = cols_eff;
              row_d         = '0;
              col_d         = '0;
              rd_addr_d     = '0;
              cmd_o.acc_clr = 1'b1;
              state_d       = ST_ISSUE;
            end else begin
              pos_d = pos_inc;
            end
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.rd   = 1'b1;
        mat_addr_o = rd_addr_q;
        vec_addr_o = col_q[CW-1:0];
        rd_addr_d  = AW'(rd_addr_q + 1'b1);
        if (CLW'(col_q + 1'b1) == cols_q) begin
          col_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          col_d = CLW'(col_q + 1'b1);
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (RLW'(row_q + 1'b1) == rows_q) begin
            cmd_o.out_last = 1'b1;
            state_d        = ST_LOAD;
          end else begin
            row_d         = RLW'(row_q + 1'b1);
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign out_row_o = RowIndexW'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pos_q       <= '0;
      vec_phase_q <= 1'b0;
      rows_q      <= '0;
      cols_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rd_addr_q   <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vec_phase_q <= vec_phase_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rd_addr_q   <= rd_addr_d;
    end
  end

endmodule

@@ sv/mvm_dp.sv @@
module mvm_dp #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16,
  localparam int unsigned MaxProd = MAX_ROWS * MAX_COLS,
  localparam int unsigned AW  = (MaxProd > 1) ? $clog2(MaxProd) : 1,
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [mvm_pkg::DataW-1:0]    element_value_i,
  input  mvm_pkg::cmd_t                       cmd_i,
  input  logic [AW-1:0]                       mat_addr_i,
  input  logic [CW-1:0]                       vec_addr_i,
  input  logic [mvm_pkg::RowIndexW-1:0]       out_row_i,
  output mvm_pkg::stat_t                      stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mvm_pkg::RowIndexW-1:0]       row_index_o,
  output logic signed [mvm_pkg::DataW-1:0]    dot_sum_o,
  output logic                                last_row_o
);
  import mvm_pkg::*;

  logic [DataW-1:0] mat_mem [MaxProd];
  logic [DataW-1:0] vec_mem [MAX_COLS];

  logic [DataW-1:0]     mat_rd_q, vec_rd_q, prod_q, acc_q;
  logic                 rd_v_q, prod_v_q, out_valid_q;
  logic [RowIndexW-1:0] row_q;
  logic                 last_q;

  // stores, registered read, then product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_wr) begin
      mat_mem[mat_addr_i] <= element_value_i;
    end
    if (cmd_i.vec_wr) begin
      vec_mem[vec_addr_i] <= element_value_i;
    end
    if (cmd_i.rd) begin
      mat_rd_q <= mat_mem[mat_addr_i];
      vec_rd_q <= vec_mem[vec_addr_i];
    end
    prod_q <= mat_rd_q * vec_rd_q;
  end

  // accumulator and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.out_load) begin
      row_q  <= out_row_i;
      last_q <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.rd;
      prod_v_q <= rd_v_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sum register is loaded together with the row fields
  logic [DataW-1:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sum_q <= acc_q;
    end
  end

  assign stat_o.pipe_busy = rd_v_q | prod_v_q;
  assign stat_o.out_free  = !out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_q;
  assign dot_sum_o   = sum_q;
  assign last_row_o  = last_q;

endmodule

@@ sv/matrix_vector_multiply.sv @@
// loading: a matrix or vector element transfer is taken every cycle while loading;
//   none is taken while the rows are computed and their results are handed out
// compute: rows one after another, one multiply-accumulate per cycle through one
//   matrix read port and a read, multiply, add pipe that drains before each result
// reset: async active low; counts go to 16, load position and phase clear,
//   matrix and vector stores are left unknown until written
module matrix_vector_multiply #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // element stream
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mvm_pkg::DataW-1:0]    element_value_i,
  // result stream
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mvm_pkg::RowIndexW-1:0]       row_index_o,
  output logic signed [mvm_pkg::DataW-1:0]    dot_sum_o,
  output logic                                last_row_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import mvm_pkg::*;

  `include "matrix_vector_multiply_assert.svh"

  localparam int unsigned MaxProd = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (MaxProd > 1) ? $clog2(MaxProd) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CountW-1:0] row_count_q, column_count_q;
  logic              reg_wr;
  reg_idx_e          reg_idx;

  // register index comes from the word address bit
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign reg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CountReset;
      column_count_q <= CountReset;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ROW_COUNT:    row_count_q    <= pwdata[CountW-1:0];
        REG_COLUMN_COUNT: column_count_q <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_COUNT:    prdata = 32'(row_count_q);
      REG_COLUMN_COUNT: prdata = 32'(column_count_q);
      default:          prdata = '0;
    endcase
  end

  // controller and datapath hookup
  cmd_t                 cmd;
  stat_t                stat;
  logic [AW-1:0]        mat_addr;
  logic [CW-1:0]        vec_addr;
  logic [RowIndexW-1:0] out_row;

  // controller: load position, phase, row and column walk
  mvm_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_count_i    (row_count_q),
    .column_count_i (column_count_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .mat_addr_o     (mat_addr),
    .vec_addr_o     (vec_addr),
    .out_row_o      (out_row)
  );

  // datapath: stores, multiplier, accumulator, output register
  mvm_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .mat_addr_i      (mat_addr),
    .vec_addr_i      (vec_addr),
    .out_row_i       (out_row),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .row_index_o     (row_index_o),
    .dot_sum_o       (dot_sum_o),
    .last_row_o      (last_row_o)
  );

  // a result is taken only after the multiply-accumulate pipe has drained
  `MVM_ASSERT_SAME(a_load_after_drain, cmd.out_load, !stat.pipe_busy)
  // accumulator clears only with an empty pipe
  `MVM_ASSERT_SAME(a_clear_when_empty, cmd.acc_clr, !stat.pipe_busy)
  // no element transfer while the stores are being read
  `MVM_ASSERT_SAME(a_no_load_during_read, cmd.rd, !in_ready_o)
  // a loaded result shows on the output next cycle
  `MVM_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid_o)

endmodule

@@ bench/tb.sv @@
module tb;
  import mvm_pkg::*;

  localparam int unsigned MaxRows     = 16;
  localparam int unsigned MaxCols     = 16;
  // cycles to let pass once no result is pending, before a register write
  localparam int unsigned SettleCycles = 40;
  // trailing window at the end, catches results that nobody asked for
  localparam int unsigned TailCycles   = 60;
  // long receiver hold-off, so the block backs up and stalls its input
  localparam int unsigned HoldCycles   = 400;
  // cycles with no transfer on either stream before the run is abandoned
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned RandomItems  = 128;

  // one expected result: row number, wrapped dot product, end-of-run flag
  typedef struct packed {
    logic [RowIndexW-1:0] row;
    logic [DataW-1:0]     sum;
    logic                 last;
  } row_result_t;

  // one line of the directed script: a register write or one element
  typedef enum logic {STEP_WRITE, STEP_ELEM} step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    reg_idx_e         idx;
    logic [31:0]      value;
    logic             typed;      // dot product of a one-row run typed in by hand
    logic [DataW-1:0] typed_sum;
  } step_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [DataW-1:0] element_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [RowIndexW-1:0]    row_index_o;
  logic signed [DataW-1:0] dot_sum_o;
  logic                    last_row_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  matrix_vector_multiply #(
    .MAX_ROWS(MaxRows),
    .MAX_COLS(MaxCols)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_index_o    (row_index_o),
    .dot_sum_o      (dot_sum_o),
    .last_row_o     (last_row_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the stores, the fill pointer and the counts
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] mat_words [MaxRows*MaxCols];
  logic [DataW-1:0] vec_words [MaxCols];
  int unsigned      fill_pos        = 0;
  bit               in_vector_phase = 1'b0;
  logic [CountW-1:0] row_cfg        = CountReset;
  logic [CountW-1:0] col_cfg        = CountReset;

  // dot products still owed by the block, oldest first
  row_result_t pending_rows[$];

  int unsigned fail_count = 0;
  bit          hold_req   = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // a count of zero behaves as one, anything past the store size as the maximum
  function automatic int unsigned eff_count(input logic [CountW-1:0] v,
                                            input int unsigned top);
    if (v == '0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // take one element into the predictor; after the last vector element the
  // row dot products are queued, using the counts that hold at that moment
  task automatic absorb_element(input logic [DataW-1:0] v, output int unsigned produced);
    int unsigned rows;
    int unsigned cols;
    logic [DataW-1:0] acc;
    row_result_t res;
    rows = eff_count(row_cfg, MaxRows);
    cols = eff_count(col_cfg, MaxCols);
    produced = 0;
    if (!in_vector_phase) begin
      if (fill_pos < MaxRows*MaxCols) mat_words[fill_pos] = v;
      fill_pos++;
      // phase ends on reaching or passing rows*cols, counts may have shrunk
      if (fill_pos >= rows*cols) begin
        fill_pos = 0;
        in_vector_phase = 1'b1;
      end
    end else begin
      if (fill_pos < MaxCols) vec_words[fill_pos] = v;
      fill_pos++;
      if (fill_pos >= cols) begin
        fill_pos = 0;
        in_vector_phase = 1'b0;
        for (int unsigned r = 0; r < rows; r++) begin
          acc = '0;
          // 32-bit context keeps the low half of each product, sums wrap
          for (int unsigned c = 0; c < cols; c++)
            acc = acc + mat_words[r*cols + c] * vec_words[c];
          res.row  = r[RowIndexW-1:0];
          res.sum  = acc;
          res.last = (r + 1 == rows);
          pending_rows.push_back(res);
        end
        produced = rows;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // register port: one APB transaction, setup then access
  // ---------------------------------------------------------------------------
  task automatic reg_access(input reg_idx_e idx, input bit is_write,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    if (is_write) begin
      if (idx == REG_ROW_COUNT) row_cfg = wdata[CountW-1:0];
      else col_cfg = wdata[CountW-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [31:0] want);
    logic [31:0] got;
    reg_access(idx, 1'b0, '0, got);
    if (got !== want) report_mismatch(idx == REG_ROW_COUNT ? "row_count readback" :
                                      "column_count readback", got, want);
  endtask

  task automatic config_write(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] unused;
    reg_access(idx, 1'b1, value, unused);
    check_reg(idx, {{(32-CountW){1'b0}}, value[CountW-1:0]});
  endtask

  // ---------------------------------------------------------------------------
  // element stream driver
  // ---------------------------------------------------------------------------
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    int small_v;
    small_v = int'($urandom_range(0, 20)) - 10;
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3, 4:    return small_v;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_input(input int unsigned n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // drop valid, wait for every owed result, then let the block go quiet
  task automatic settle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // valid stays high from one element to the next unless a gap is inserted
  task automatic send_element(input logic [DataW-1:0] v, input logic typed,
                              input logic [DataW-1:0] typed_sum);
    int unsigned produced;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    absorb_element(v, produced);
    if (typed && produced == 1) pending_rows[pending_rows.size() - 1].sum = typed_sum;
  endtask

  function automatic step_t set_reg(input reg_idx_e idx, input logic [31:0] v);
    return '{kind: STEP_WRITE, idx: idx, value: v, typed: 1'b0, typed_sum: '0};
  endfunction

  function automatic step_t elem(input logic [DataW-1:0] v);
    return '{kind: STEP_ELEM, idx: REG_ROW_COUNT, value: v, typed: 1'b0, typed_sum: '0};
  endfunction

  function automatic step_t elem_sum(input logic [DataW-1:0] v, input logic [DataW-1:0] s);
    return '{kind: STEP_ELEM, idx: REG_ROW_COUNT, value: v, typed: 1'b1, typed_sum: s};
  endfunction

  // one random matrix and vector; some sets keep the counts and follow the
  // previous one straight on, its elements held off until its dot products are done
  task automatic random_set(input int unsigned set_no, inout int unsigned sent);
    logic [CountW-1:0] rows_v;
    logic [CountW-1:0] cols_v;
    bit new_cfg;
    bit burst;
    int unsigned rows;
    int unsigned cols;
    int unsigned n;
    rows_v  = CountW'($urandom_range(1, 4));
    cols_v  = CountW'($urandom_range(1, 4));
    new_cfg = ($urandom_range(0, 1) == 0);
    case (set_no)
      0: begin rows_v = 5'd1;  cols_v = 5'd31; new_cfg = 1'b1; end  // columns past max
      1: begin rows_v = 5'd16; cols_v = 5'd1;  new_cfg = 1'b1; end  // rows at max
      2: begin rows_v = 5'd4;  cols_v = 5'd4;  new_cfg = 1'b1; end  // before the hold-off
      3: new_cfg = 1'b0;                                            // runs into the hold-off
      default: begin
        case ($urandom_range(0, 19))
          0: rows_v = 5'd0;
          1: rows_v = CountW'($urandom_range(16, 31));
          default: ;
        endcase
        case ($urandom_range(0, 19))
          0: cols_v = 5'd0;
          1: cols_v = CountW'($urandom_range(16, 31));
          default: ;
        endcase
        // keep sets short, large counts only along one side
        if (eff_count(rows_v, MaxRows) * eff_count(cols_v, MaxCols) > 32)
          cols_v = CountW'($urandom_range(0, 2));
      end
    endcase
    if (new_cfg) begin
      settle_input();
      config_write(REG_ROW_COUNT, 32'(rows_v));
      config_write(REG_COLUMN_COUNT, 32'(cols_v));
    end
    rows  = eff_count(row_cfg, MaxRows);
    cols  = eff_count(col_cfg, MaxCols);
    n     = rows*cols + cols;
    burst = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < n; k++) begin
      if (!burst && $urandom_range(0, 2) == 0) idle_input(gap_length());
      send_element(pick_value(), 1'b0, '0);
      sent++;
      // sender pause halfway into a matrix, until the block has nothing owed
      if (set_no == 4 && k == rows*cols/2) settle_input();
    end
    // results of this set start flowing, the receiver now sits on them
    if (set_no == 2) hold_req = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_t script_q[$];
    int unsigned sent;
    int unsigned set_no;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    element_value_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // both counts come out of reset at the store size
    check_reg(REG_ROW_COUNT, 32'd16);
    check_reg(REG_COLUMN_COUNT, 32'd16);

    script_q = {
      // one by one: products at the corners of the signed range
      set_reg(REG_ROW_COUNT, 1), set_reg(REG_COLUMN_COUNT, 1),
      elem(32'h8000_0000), elem_sum(32'h8000_0000, 32'h0000_0000),
      elem(32'h7fff_ffff), elem_sum(32'h7fff_ffff, 32'h0000_0001),
      elem(32'h7fff_ffff), elem_sum(32'hffff_ffff, 32'h8000_0001),
      // zero counts act as one
      set_reg(REG_ROW_COUNT, 0), set_reg(REG_COLUMN_COUNT, 0),
      elem(32'hffff_ffff), elem_sum(32'hffff_ffff, 32'h0000_0001),
      // row count past the store size acts as sixteen rows
      set_reg(REG_ROW_COUNT, 17), set_reg(REG_COLUMN_COUNT, 1),
      elem(32'd1), elem(32'hffff_fffe), elem(32'd3), elem(32'hffff_fffc),
      elem(32'h7fff_ffff), elem(32'h8000_0000), elem(32'd100), elem(32'd0),
      elem(32'h0001_0000), elem(32'hffff_ffff), elem(32'h5555_5555), elem(32'haaaa_aaaa),
      elem(32'd12345), elem(32'hfffe_0000), elem(32'd7), elem(32'h4000_0000),
      elem(32'hffff_fffd),
      // counts changed while loading: the matrix is already past the new size,
      // then the vector grows, then it shrinks to what was already taken
      set_reg(REG_ROW_COUNT, 2), set_reg(REG_COLUMN_COUNT, 2),
      elem(32'd5), elem(32'hffff_fffa), elem(32'h4000_0000),
      set_reg(REG_COLUMN_COUNT, 1),
      elem(32'd9),
      set_reg(REG_COLUMN_COUNT, 2),
      elem(32'h0001_0001),
      set_reg(REG_COLUMN_COUNT, 1),
      elem(32'd3)
    };

    foreach (script_q[i]) begin
      if (script_q[i].kind == STEP_WRITE) begin
        settle_input();
        config_write(script_q[i].idx, script_q[i].value);
      end else begin
        if ($urandom_range(0, 3) == 0) idle_input(gap_length());
        send_element(script_q[i].value, script_q[i].typed, script_q[i].typed_sum);
      end
    end

    // random sets until enough elements have gone in
    sent   = 0;
    set_no = 0;
    while (sent < RandomItems) begin
      random_set(set_no, sent);
      set_no++;
    end

    // wait out everything owed, then a quiet tail for stray results
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** matrix_vector_multiply: PASSED **");
    end else begin
      $display("** matrix_vector_multiply: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, steady stretches, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall_left;
    int unsigned phase_cnt;
    bit steady;
    out_ready_i = 1'b0;
    stall_left  = 0;
    phase_cnt   = 0;
    steady      = 1'b0;
    forever begin
      @(negedge clk_i);
      phase_cnt++;
      if (phase_cnt % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each transfer against the oldest owed dot product
  // ---------------------------------------------------------------------------
  row_result_t want_row;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("result with none owed, dot_sum", dot_sum_o, '0);
      end else begin
        want_row = pending_rows.pop_front();
        if (row_index_o !== want_row.row)
          report_mismatch("row_index", 32'(row_index_o), 32'(want_row.row));
        if (dot_sum_o !== want_row.sum)
          report_mismatch("dot_sum", dot_sum_o, want_row.sum);
        if (last_row_o !== want_row.last)
          report_mismatch("last_row", 32'(last_row_o), 32'(want_row.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no transfer on either stream
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("** matrix_vector_multiply: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
